### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define HC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// clocked check that also holds during reset
`define HC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define HC_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define HC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

### sv/hc_pkg.sv
// shared types, constants and mod-26 helpers for the 2x2 hill cipher
package hc_pkg;

  localparam int MODULUS    = 26;
  localparam int PAD_LETTER = 23;
  // floor(x / 26) == (x * 2521) >> 16 for every x below 2048
  localparam int MOD_RECIP  = 2521;
  localparam int KEY_LAT    = 5;
  localparam int Q_DEPTH_DEF = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_TL   = 3'd0;
  localparam logic [2:0] CFG_KEY_TR   = 3'd1;
  localparam logic [2:0] CFG_KEY_BL   = 3'd2;
  localparam logic [2:0] CFG_KEY_BR   = 3'd3;
  localparam logic [2:0] CFG_DECRYPT  = 3'd4;

  // register reset values
  localparam logic [4:0] RST_KEY_TL = 5'd3;
  localparam logic [4:0] RST_KEY_TR = 5'd3;
  localparam logic [4:0] RST_KEY_BL = 5'd2;
  localparam logic [4:0] RST_KEY_BR = 5'd5;

  typedef struct packed {
    logic [4:0] letter;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       last_out;
    logic       key_error;
  } out_word_t;

  typedef struct packed {
    logic [4:0] p0;
    logic [4:0] p1;
    logic       eom;
  } pair_t;

  typedef struct packed {
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    logic [4:0] d;
    logic       err;
  } key_mat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RED,
    B_SEND0,
    B_SEND1
  } back_state_t;

  typedef struct packed {
    back_state_t state;
    logic        pop;
  } back_stat_t;

  // single conditional subtract for values below 32
  function automatic logic [4:0] red26_f(input logic [4:0] x);
    logic [4:0] r;
    r = (x >= 5'(MODULUS)) ? x - 5'(MODULUS) : x;
    return r;
  endfunction

  // reciprocal multiply, exact for x below 2048
  function automatic logic [4:0] mod26_f(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  quo;
    logic [10:0] rem;
    prod = 23'(x) * 23'(MOD_RECIP);
    quo  = prod[22:16];
    rem  = x - 11'(quo) * 11'(MODULUS);
    return rem[4:0];
  endfunction

  // inverse mod 26; {ok, factor}, factor 25 when no inverse exists
  function automatic logic [5:0] inv26_f(input logic [4:0] d);
    logic [5:0] r;
    case (d)
      5'd1:    r = {1'b1, 5'd1};
      5'd3:    r = {1'b1, 5'd9};
      5'd5:    r = {1'b1, 5'd21};
      5'd7:    r = {1'b1, 5'd15};
      5'd9:    r = {1'b1, 5'd3};
      5'd11:   r = {1'b1, 5'd19};
      5'd15:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd23};
      5'd19:   r = {1'b1, 5'd11};
      5'd21:   r = {1'b1, 5'd5};
      5'd23:   r = {1'b1, 5'd17};
      5'd25:   r = {1'b1, 5'd25};
      default: r = {1'b0, 5'd25};
    endcase
    return r;
  endfunction

endpackage

### sv/hc_front.sv
// front end: takes letters, reduces them and groups them into pairs
module hc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hc_pkg::in_word_t in_word,
  input  logic             q_full,
  output logic             q_push,
  output hc_pkg::pair_t    q_data
);
  import hc_pkg::*;

  logic       pend_r, pend_nxt;
  logic [4:0] held_r, held_nxt;
  logic       acc;
  logic [4:0] lt;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign lt       = red26_f(in_word.letter);

  // pairing: second letter or a lone final letter completes a pair
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    q_push   = 1'b0;
    q_data   = '{p0: lt, p1: 5'(PAD_LETTER), eom: in_word.end_of_message};
    if (acc) begin
      if (pend_r) begin
        q_push   = 1'b1;
        q_data   = '{p0: held_r, p1: lt, eom: in_word.end_of_message};
        pend_nxt = 1'b0;
      end else if (in_word.end_of_message) begin
        q_push   = 1'b1;
      end else begin
        pend_nxt = 1'b1;
        held_nxt = lt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

### sv/hc_queue.sv
// small fifo of letter pairs between front and back
module hc_queue #(
  parameter int DEPTH = hc_pkg::Q_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hc_pkg::pair_t wdata,
  input  logic          pop,
  output hc_pkg::pair_t rdata,
  output logic          not_empty,
  output logic          full
);
  import hc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign rdata     = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/hc_keygen.sv
// key registers and the pipeline that derives the working matrix
module hc_keygen (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_data,
  output hc_pkg::key_mat_t key_mat,
  output logic             key_busy
);
  import hc_pkg::*;

  logic [4:0]  tl_r, tr_r, bl_r, br_r;
  logic        dec_r;
  logic [2:0]  busy_r, busy_nxt;
  logic [4:0]  ka_r, kb_r, kc_r, kd_r;
  logic        mode_r;
  logic [9:0]  ad_r, bc_r;
  logic [4:0]  f_r;
  logic        ok_r;
  logic [9:0]  pa_r, pb_r, pc_r, pd_r;
  key_mat_t    mat_r;
  logic [10:0] det_raw;
  logic [5:0]  inv;
  logic [4:0]  fsel, ea, eb, ec, ed, nb, nc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r  <= RST_KEY_TL;
      tr_r  <= RST_KEY_TR;
      bl_r  <= RST_KEY_BL;
      br_r  <= RST_KEY_BR;
      dec_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TL:  tl_r  <= cfg_data;
        CFG_KEY_TR:  tr_r  <= cfg_data;
        CFG_KEY_BL:  bl_r  <= cfg_data;
        CFG_KEY_BR:  br_r  <= cfg_data;
        CFG_DECRYPT: dec_r <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // settle counter: matrix is trusted once the pipeline has refilled
  always_comb begin
    busy_nxt = busy_r;
    if (cfg_we) begin
      busy_nxt = 3'(KEY_LAT);
    end else if (busy_r != '0) begin
      busy_nxt = busy_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 3'(KEY_LAT);
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign key_busy = (busy_r != '0);

  // determinant and inverse lookup
  assign det_raw = 11'(ad_r) + 11'(MODULUS * MODULUS) - 11'(bc_r);
  assign inv     = inv26_f(mod26_f(det_raw));

  // adjugate selection in decrypt mode
  assign nb   = (kb_r == '0) ? '0 : 5'(MODULUS) - kb_r;
  assign nc   = (kc_r == '0) ? '0 : 5'(MODULUS) - kc_r;
  assign fsel = mode_r ? f_r  : 5'd1;
  assign ea   = mode_r ? kd_r : ka_r;
  assign eb   = mode_r ? nb   : kb_r;
  assign ec   = mode_r ? nc   : kc_r;
  assign ed   = mode_r ? ka_r : kd_r;

  // five register stages: reduce, products, inverse, scale, reduce
  always_ff @(posedge clk) begin
    ka_r   <= red26_f(tl_r);
    kb_r   <= red26_f(tr_r);
    kc_r   <= red26_f(bl_r);
    kd_r   <= red26_f(br_r);
    mode_r <= dec_r;
    ad_r   <= 10'(ka_r) * 10'(kd_r);
    bc_r   <= 10'(kb_r) * 10'(kc_r);
    f_r    <= inv[4:0];
    ok_r   <= inv[5];
    pa_r   <= 10'(ea) * 10'(fsel);
    pb_r   <= 10'(eb) * 10'(fsel);
    pc_r   <= 10'(ec) * 10'(fsel);
    pd_r   <= 10'(ed) * 10'(fsel);
    mat_r  <= '{a:   mod26_f(11'(pa_r)),
                b:   mod26_f(11'(pb_r)),
                c:   mod26_f(11'(pc_r)),
                d:   mod26_f(11'(pd_r)),
                err: mode_r && !ok_r};
  end

  assign key_mat = mat_r;

endmodule

### sv/hc_back.sv
// back end: multiplies a pair by the matrix and sends two words
module hc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hc_pkg::key_mat_t  key_mat,
  input  logic              key_busy,
  input  logic              q_not_empty,
  input  hc_pkg::pair_t     q_data,
  output hc_pkg::back_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output hc_pkg::out_word_t out_word
);
  import hc_pkg::*;

  back_state_t state_r, state_nxt;
  logic [10:0] sum0_r, sum1_r;
  logic [4:0]  c0_r, c1_r;
  logic        eom_r;
  logic        pop;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_not_empty && !key_busy) state_nxt = B_RED;
      B_RED:   state_nxt = B_SEND0;
      B_SEND0: if (!out_stall) state_nxt = B_SEND1;
      B_SEND1: if (!out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    out_word  = '{out_letter: c0_r, last_out: 1'b0, key_error: key_mat.err};
    case (state_r)
      B_IDLE:  pop = q_not_empty && !key_busy;
      B_RED:   ;
      B_SEND0: out_valid = 1'b1;
      B_SEND1: begin
        out_valid = 1'b1;
        out_word  = '{out_letter: c1_r, last_out: eom_r, key_error: key_mat.err};
      end
      default: ;
    endcase
  end

  assign stat = '{state: state_r, pop: pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // dot products on pop, then mod-26 reduction
  always_ff @(posedge clk) begin
    if (pop) begin
      sum0_r <= 11'(10'(key_mat.a) * 10'(q_data.p0)) + 11'(10'(key_mat.b) * 10'(q_data.p1));
      sum1_r <= 11'(10'(key_mat.c) * 10'(q_data.p0)) + 11'(10'(key_mat.d) * 10'(q_data.p1));
      eom_r  <= q_data.eom;
    end
    if (state_r == B_RED) begin
      c0_r <= mod26_f(sum0_r);
      c1_r <= mod26_f(sum1_r);
    end
  end

endmodule

### sv/hill_cipher_2x2.sv
// top level of the 2x2 mod-26 hill cipher
// usage:
//   letters enter on in_valid/in_stall as in_word (letter, end_of_message);
//   values 26..31 are folded into range. letters are paired; a message that
//   ends on the first letter of a pair is padded with X.
//   each completed pair yields two words on out_valid/out_stall; the second
//   carries last_out when the pair ended the message. key_error is set on
//   both words when decrypting with a key whose determinant has no inverse.
//   key and mode are written through cfg_we/cfg_index/cfg_data while idle.
// flow:
//   the first result word is offered once its pair has been queued, popped,
//   multiplied and reduced; the second word follows in the cycle after the
//   first is taken. the back sequencer takes a new pair only after both
//   words of the current pair are sent (reduce, send0, send1, idle);
//   a 2-entry pair queue lets input run ahead while output is stalled.
//   after a key write the matrix pipeline must refill to settle; the back
//   end waits for it before starting a pair.
// reset:
//   synchronous, active low; restores the default key, encrypt mode, clears
//   the held letter and the queue. out_stall holds the current word stable.
`include "assert_macros.svh"
module hill_cipher_2x2 #(
  parameter int QUEUE_DEPTH = hc_pkg::Q_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hc_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output hc_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [4:0]        cfg_data
);
  import hc_pkg::*;

  logic       q_push, q_full, q_not_empty;
  pair_t      q_wdata, q_rdata;
  key_mat_t   key_mat;
  logic       key_busy;
  back_stat_t bstat;

  // letter pairing
  hc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // pair queue
  hc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (bstat.pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // key registers and matrix derivation
  hc_keygen u_keygen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_mat   (key_mat),
    .key_busy  (key_busy)
  );

  // matrix multiply and output sequencing
  hc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_mat     (key_mat),
    .key_busy    (key_busy),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .stat        (bstat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  // checks
  `HC_ASSERT(a_no_push_full, clk, rst_n, (q_push |-> !q_full), "push into full pair queue")
  `HC_ASSERT(a_pop_needs_data, clk, rst_n, (bstat.pop |-> (q_not_empty && !key_busy)), "bad pop")
  `HC_ASSERT(a_pop_to_red, clk, rst_n, (bstat.pop |=> bstat.state == B_RED), "no reduce step")
  `HC_ASSERT(a_last_pos, clk, rst_n, out_word.last_out |-> bstat.state == B_SEND1, "last early")
  `HC_ASSERT_ALWAYS(a_rst_idle, clk, (!rst_n |=> bstat.state == B_IDLE), "not idle after reset")

endmodule

### tb/sv/tb_hill_cipher_2x2.sv
// self-checking testbench for the 2x2 mod-26 hill cipher
module tb_hill_cipher_2x2;

  localparam int IDLE_PCT    = 23;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 400;
  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  hc_pkg::in_word_t  in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  hc_pkg::out_word_t out_word;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = hc_pkg::CFG_KEY_TL;
  logic [4:0]        cfg_data = '0;

  // letters waiting to be offered, and cipher words still owed by the block
  hc_pkg::in_word_t  letters_to_send[$];
  hc_pkg::out_word_t cipher_words_due[$];

  // shadow copy of the key registers and pairing state
  logic [4:0] key_tl = hc_pkg::RST_KEY_TL;
  logic [4:0] key_tr = hc_pkg::RST_KEY_TR;
  logic [4:0] key_bl = hc_pkg::RST_KEY_BL;
  logic [4:0] key_br = hc_pkg::RST_KEY_BR;
  logic       decrypting = 1'b0;
  logic       first_held = 1'b0;
  int         held_value = 0;

  bit quiet = 1'b0;
  int fail_count = 0;
  int letters_taken = 0;
  int words_checked = 0;
  int error_words = 0;
  int key_settings = 1;
  int idle_cycles = 0;

  hill_cipher_2x2 uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // pair letters and work out the cipher words each letter causes
  task automatic encipher_letter(input hc_pkg::in_word_t w);
    int letter, p0, p1, ka, kb, kc, kd, det, scale, tmp;
    bit invertible;
    hc_pkg::out_word_t r;
    letter = int'(w.letter) % hc_pkg::MODULUS;
    if (first_held) begin
      p0 = held_value;
      p1 = letter;
    end else if (w.end_of_message) begin
      p0 = letter;
      p1 = hc_pkg::PAD_LETTER;
    end else begin
      held_value = letter;
      first_held = 1'b1;
      return;
    end
    first_held = 1'b0;
    held_value = 0;
    ka = int'(key_tl) % hc_pkg::MODULUS;
    kb = int'(key_tr) % hc_pkg::MODULUS;
    kc = int'(key_bl) % hc_pkg::MODULUS;
    kd = int'(key_br) % hc_pkg::MODULUS;
    invertible = 1'b1;
    if (decrypting) begin
      // inverse key: adjugate times det^-1, or times -1 when det has no inverse
      det = (ka * kd - kb * kc + hc_pkg::MODULUS * hc_pkg::MODULUS) % hc_pkg::MODULUS;
      scale = hc_pkg::MODULUS - 1;
      invertible = 1'b0;
      for (int x = 1; x < hc_pkg::MODULUS; x++) begin
        if (!invertible && (det * x) % hc_pkg::MODULUS == 1) begin
          scale = x;
          invertible = 1'b1;
        end
      end
      tmp = ka;
      ka = (kd * scale) % hc_pkg::MODULUS;
      kb = (((hc_pkg::MODULUS - kb) % hc_pkg::MODULUS) * scale) % hc_pkg::MODULUS;
      kc = (((hc_pkg::MODULUS - kc) % hc_pkg::MODULUS) * scale) % hc_pkg::MODULUS;
      kd = (tmp * scale) % hc_pkg::MODULUS;
    end
    r.key_error = decrypting && !invertible;
    r.out_letter = 5'((ka * p0 + kb * p1) % hc_pkg::MODULUS);
    r.last_out = 1'b0;
    cipher_words_due.push_back(r);
    r.out_letter = 5'((kc * p0 + kd * p1) % hc_pkg::MODULUS);
    r.last_out = w.end_of_message;
    cipher_words_due.push_back(r);
  endtask

  // letter driver: holds a word until taken, idles only between words
  always @(posedge clk) begin : drive_letters
    logic took;
    took = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        encipher_letter(in_word);
        void'(letters_to_send.pop_front());
        letters_taken++;
      end
      if (in_valid && !took) begin
        in_valid <= 1'b1;
      end else if (letters_to_send.size() != 0 &&
                   (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_word <= letters_to_send[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // cipher word monitor and receiver stall, with one long hold-off
  always @(posedge clk) begin : check_words
    hc_pkg::out_word_t want;
    int hold_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_words_due.size() == 0) begin
          $error("out_word: no word expected, got letter %0d last %0b error %0b",
                 out_word.out_letter, out_word.last_out, out_word.key_error);
          fail_count++;
        end else begin
          want = cipher_words_due.pop_front();
          if (out_word.out_letter !== want.out_letter) begin
            $error("out_letter: expected %0d, got %0d", want.out_letter,
                   out_word.out_letter);
            fail_count++;
          end
          if (out_word.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_word.last_out);
            fail_count++;
          end
          if (out_word.key_error !== want.key_error) begin
            $error("key_error: expected %0b, got %0b", want.key_error,
                   out_word.key_error);
            fail_count++;
          end
          if (want.key_error) error_words++;
          words_checked++;
          if (words_checked == HOLD_AT) hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles where neither side moves a word and no register is written
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_letter(input int value, input bit eom);
    hc_pkg::in_word_t w;
    w.letter = 5'(value);
    w.end_of_message = eom;
    letters_to_send.push_back(w);
  endtask

  // messages of random length; some carry scattered end marks as noise
  task automatic add_messages(input int count);
    int added, len, value;
    bit noisy;
    added = 0;
    while (added < count) begin
      len = $urandom_range(12, 1);
      noisy = ($urandom_range(7) == 0);
      for (int i = 0; i < len; i++) begin
        value = ($urandom_range(99) < 10) ? $urandom_range(31, 26) : $urandom_range(25, 0);
        add_letter(value, noisy ? 1'($urandom_range(1)) : (i == len - 1));
      end
      added += len;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (letters_to_send.size() != 0 || cipher_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      hc_pkg::CFG_KEY_TL:  key_tl = value;
      hc_pkg::CFG_KEY_TR:  key_tr = value;
      hc_pkg::CFG_KEY_BL:  key_bl = value;
      hc_pkg::CFG_KEY_BR:  key_br = value;
      hc_pkg::CFG_DECRYPT: decrypting = value[0];
      default: ;
    endcase
  endtask

  // load a new key and mode once the block has gone quiet
  task automatic load_key(input logic [4:0] a, input logic [4:0] b, input logic [4:0] c,
                          input logic [4:0] d, input logic mode);
    wait_drained();
    repeat (hc_pkg::KEY_LAT + 5) @(posedge clk);
    write_reg(hc_pkg::CFG_KEY_TL, a);
    write_reg(hc_pkg::CFG_KEY_TR, b);
    write_reg(hc_pkg::CFG_KEY_BL, c);
    write_reg(hc_pkg::CFG_KEY_BR, d);
    write_reg(hc_pkg::CFG_DECRYPT, {4'd0, mode});
    @(posedge clk);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  // stimulus sequence
  initial begin
    wait (rst_n);
    @(negedge clk);

    // directed: default key, pairs, odd ends, out-of-range letters
    add_letter(0, 0);  add_letter(31, 1);
    add_letter(25, 1);
    add_letter(31, 1);
    add_letter(26, 0); add_letter(27, 0);
    add_letter(13, 0); add_letter(1, 1);
    add_letter(0, 1);
    add_letter(25, 0); add_letter(25, 0);
    add_letter(31, 0); add_letter(31, 1);
    add_letter(7, 0);  add_letter(30, 1);
    add_letter(12, 0);

    // all-zero key in encrypt
    load_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
    add_messages(100);

    // all-ones key in decrypt: singular, reads as 5s
    load_key(5'd31, 5'd31, 5'd31, 5'd31, 1'b1);
    add_messages(150);

    // default key in decrypt: invertible; long receiver hold lands here
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
    add_messages(250);

    // out-of-range entries, no idling on either side
    load_key(5'd25, 5'd26, 5'd30, 5'd27, 1'b0);
    quiet = 1'b1;
    add_messages(200);
    wait_drained();
    quiet = 1'b0;

    // random keys and modes
    for (int p = 0; p < 6; p++) begin
      load_key(5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
               5'($urandom_range(31)), 1'($urandom_range(1)));
      add_messages(180);
    end

    wait_drained();
    repeat (hc_pkg::KEY_LAT + 20) @(posedge clk);
    if (cipher_words_due.size() != 0) begin
      $error("out_word: %0d words never arrived", cipher_words_due.size());
      fail_count++;
    end
    $display("covered %0d letters and %0d cipher words over %0d key settings",
             letters_taken, words_checked, key_settings);
    $display("%0d words carried a singular-key error; %0d mismatches", error_words,
             fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
